@@ hdl/gcb_pkg.sv @@
// Shared types and codes for the glyph column blitter.
package gcb_pkg;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] FULL_BYTE = 8'hff;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  column_x;
		logic [6:0]  row_y;
		logic        tall_font;
		logic        keep_polarity;
		logic [31:0] glyph_bits;
		logic [11:0] byte_address;
		logic [7:0]  byte_value;
	} in_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       out_of_range;
	} out_t;

endpackage

@@ hdl/gcb_merge.sv @@
// Shifts a glyph column down by the row offset and merges the edge bytes.
module gcb_merge (
	input  logic [31:0] src,
	input  logic [2:0]  shift,
	input  logic        nb4,
	input  logic [2:0]  idx,
	input  logic [7:0]  top_byte,
	input  logic [7:0]  bot_byte,
	output logic [7:0]  dst
);

	logic [39:0] cat;
	logic [39:0] shifted;
	logic [7:0]  low_mask;
	logic [7:0]  raw;
	logic [2:0]  nb;

	assign cat      = {src[7:0], src[15:8], src[23:16], src[31:24], 8'h00};
	assign shifted  = cat >> shift;
	assign low_mask = gcb_pkg::FULL_BYTE >> shift;
	assign nb       = nb4 ? 3'd4 : 3'd2;

	always_comb begin
		unique case (idx)
			3'd0:    raw = shifted[39:32];
			3'd1:    raw = shifted[31:24];
			3'd2:    raw = shifted[23:16];
			3'd3:    raw = shifted[15:8];
			3'd4:    raw = shifted[7:0];
			default: raw = '0;
		endcase
	end

	always_comb begin
		dst = raw;
		if (shift != 3'd0) begin
			if (idx == 3'd0)
				dst = dst | (top_byte & ~low_mask);
			if (idx == nb)
				dst = dst | (bot_byte & low_mask);
		end
	end

endmodule

@@ hdl/glyph_column_blit_top.sv @@
// Glyph column blitter: frame store, sequencer and result register.
// Put: two or four byte writes (tall glyph) without row shift, three or five with a row shift
// (the top and bottom edge bytes are read first, then the glyph bytes are written through the frame memory).
// Byte write: one memory write; byte read: one memory read; unused action: no memory access.
// The result is registered on hand-off. Reset clears control state and then sweeps the frame
// memory to zero, one byte per cycle over all STORE_BYTES bytes, during which no input beat is taken.
module glyph_column_blit_top #(
	parameter int COLUMN_BYTES = 16,
	parameter int STORE_BYTES  = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gcb_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output gcb_pkg::out_t  out_data
);

	localparam int PUT_W   = $clog2(256 * COLUMN_BYTES + 32);
	localparam int STORE_W = $clog2(STORE_BYTES + 1);
	localparam int PS_W    = (PUT_W > STORE_W) ? PUT_W : STORE_W;
	localparam int EXT_W   = (PS_W > 12) ? PS_W : 12;
	localparam int MEM_AW  = $clog2(STORE_BYTES);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RTOP  = 3'd2;
	localparam logic [2:0] ST_RBOT  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_RBYTE = 3'd5;
	localparam logic [2:0] ST_RDATA = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [7:0] mem [STORE_BYTES];

	logic [2:0]        state_q;
	logic [MEM_AW-1:0] clr_q;
	logic [1:0]        act_q;
	logic [EXT_W-1:0]  base_q;
	logic [2:0]        shift_q;
	logic              nb4_q;
	logic [31:0]       src_q;
	logic [7:0]        value_q;
	logic [2:0]        idx_q;
	logic              flag_q;
	logic              rd_ok_q;
	logic [7:0]        rdata_q;
	logic [7:0]        top_q;
	logic [7:0]        bot_q;
	gcb_pkg::out_t     res_q;
	logic              out_valid_q;
	gcb_pkg::out_t     out_q;

	logic [EXT_W-1:0]  nb_ext;
	logic [EXT_W-1:0]  rd_addr;
	logic              rd_in;
	logic              rd_en;
	logic [EXT_W-1:0]  wr_addr;
	logic              wr_in;
	logic              wr_en;
	logic [MEM_AW-1:0] wr_idx;
	logic [7:0]        wr_data;
	logic [7:0]        put_byte;
	logic [2:0]        last_idx;
	logic              accept;
	logic              hand_off;
	logic [31:0]       pol_bits;

	assign nb_ext   = nb4_q ? EXT_W'(4) : EXT_W'(2);
	assign rd_addr  = (state_q == ST_RBOT) ? base_q + nb_ext : base_q;
	assign rd_in    = rd_addr < EXT_W'(STORE_BYTES);
	assign rd_en    = rd_in && (state_q == ST_RTOP || state_q == ST_RBOT ||
		state_q == ST_RBYTE);
	assign wr_addr  = base_q + EXT_W'(idx_q);
	assign wr_in    = wr_addr < EXT_W'(STORE_BYTES);
	assign last_idx = (act_q == gcb_pkg::ACT_WRITE) ? 3'd0 :
		(nb4_q ? 3'd3 : 3'd1) + ((shift_q != 3'd0) ? 3'd1 : 3'd0);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign hand_off  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pol_bits  = in_data.keep_polarity ? in_data.glyph_bits : ~in_data.glyph_bits;

	gcb_merge u_merge (
		.src      (src_q),
		.shift    (shift_q),
		.nb4      (nb4_q),
		.idx      (idx_q),
		.top_byte (top_q),
		.bot_byte (bot_q),
		.dst      (put_byte)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_idx  = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == ST_WRITE) && wr_in;
			wr_idx  = wr_addr[MEM_AW-1:0];
			wr_data = (act_q == gcb_pkg::ACT_WRITE) ? value_q : put_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr[MEM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= in_data.action;
			shift_q <= in_data.row_y[2:0];
			nb4_q   <= in_data.tall_font;
			src_q   <= in_data.tall_font ? pol_bits : {16'h0000, pol_bits[15:0]};
			value_q <= in_data.byte_value;
			if (in_data.action == gcb_pkg::ACT_PUT)
				base_q <= EXT_W'(in_data.column_x) * EXT_W'(COLUMN_BYTES) +
					EXT_W'(in_data.row_y[6:3]);
			else
				base_q <= EXT_W'(in_data.byte_address);
		end
		if (state_q == ST_RTOP || state_q == ST_RBOT || state_q == ST_RBYTE)
			rd_ok_q <= rd_in;
		if (state_q == ST_RBOT)
			top_q <= rd_ok_q ? rdata_q : '0;
		if (state_q == ST_WRITE && idx_q == 3'd0)
			bot_q <= rd_ok_q ? rdata_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			flag_q      <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && !hand_off)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(STORE_BYTES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					idx_q  <= '0;
					flag_q <= 1'b0;
					res_q  <= '0;
					if (accept) begin
						priority if (in_data.action == gcb_pkg::ACT_PUT)
							state_q <= (in_data.row_y[2:0] != 3'd0) ? ST_RTOP : ST_WRITE;
						else if (in_data.action == gcb_pkg::ACT_WRITE)
							state_q <= ST_WRITE;
						else if (in_data.action == gcb_pkg::ACT_READ)
							state_q <= ST_RBYTE;
						else
							state_q <= ST_DONE;
					end
				end
				ST_RTOP:  state_q <= ST_RBOT;
				ST_RBOT:  state_q <= ST_WRITE;
				ST_WRITE: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == last_idx) begin
						res_q.out_of_range <= flag_q || !wr_in;
						state_q            <= ST_DONE;
					end else begin
						flag_q <= flag_q || !wr_in;
					end
				end
				ST_RBYTE: state_q <= ST_RDATA;
				ST_RDATA: begin
					res_q.read_value   <= rd_ok_q ? rdata_q : '0;
					res_q.out_of_range <= !rd_ok_q;
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					if (hand_off) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("input beat offered to during clear sweep");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> idx_q <= 3'd4)
		else $error("write index past last glyph byte");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.out_of_range && out_data.read_value != 8'h00))
		else $error("dropped access returned data");

	a_hand_off: assert property (@(posedge clk) disable iff (!arst_n)
		hand_off |=> out_valid && state_q == ST_IDLE)
		else $error("result not presented after completion");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && state_q != ST_CLEAR |-> state_q == ST_WRITE && wr_in)
		else $error("frame memory written outside write phase");

endmodule
